/* hw/rtl/fdd_pkg.sv */
// Shared constants and types for the frame duplicate detector.
// No dependencies; every other file imports this package.
package fdd_pkg;

  // Signature capacity and derived widths
  localparam int MAX_CELLS = 1024;
  localparam int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 18;
  localparam int AVG_W     = 12;
  localparam int LIM_W     = AVG_W + CNT_W;
  localparam int CMP_W     = (SUM_W + 4 > LIM_W) ? SUM_W + 4 : LIM_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int OUT_CNT_W = 11;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Gray weights, 16-bit fixed point, summing to 65536
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVG_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT = CFG_IDX_W'(1);

  // One pixel request after the front stage
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [IDX_W-1:0] idx;
    logic             cmp_en;   // compare against stored signature
    logic             wr_en;    // store gray into signature
    logic             last;
    logic             comp;     // frame comparable so far
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic [LIM_W-1:0] limit;    // avg_limit_x16 * count
  } item_t;

  // Forwarding bypass from the write side to the next read
  typedef struct packed {
    logic             hit;
    logic [PIX_W-1:0] gray;
  } fwd_t;

endpackage

/* hw/rtl/fdd_sig_ram.sv */
// Signature memory: one write port, one registered read port.
// Depends on fdd_pkg for depth and widths.
module fdd_sig_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [fdd_pkg::IDX_W-1:0] waddr,
  input  logic [fdd_pkg::PIX_W-1:0] wdata,
  input  logic [fdd_pkg::IDX_W-1:0] raddr,
  output logic [fdd_pkg::PIX_W-1:0] rdata
);
  import fdd_pkg::*;

  logic [PIX_W-1:0] mem [MAX_CELLS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/fdd_front.sv */
// Front stage: gray conversion, cell indexing, frame bookkeeping, read issue.
// Depends on fdd_pkg; feeds fdd_accum and fdd_sig_ram.
module fdd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic                      frame_last,
  input  logic [fdd_pkg::AVG_W-1:0] avg_limit_x16,
  output logic                      s1_valid,
  output fdd_pkg::item_t            s1,
  output fdd_pkg::fwd_t             fwd,
  output logic [fdd_pkg::IDX_W-1:0] rd_addr
);
  import fdd_pkg::*;

  logic [CNT_W-1:0] cell_index;
  logic [CNT_W-1:0] prior_count;
  logic             overflow_seen;

  logic             accept;
  logic             in_room;
  logic [CNT_W-1:0] count_next;
  logic             ovf_next;
  logic [23:0]      gray_acc;
  item_t            item_next;

  assign accept  = in_valid && advance;
  assign in_room = cell_index < CNT_W'(MAX_CELLS);

  // Build the request for this pixel
  always_comb begin
    gray_acc   = 24'(W_RED * 24'(red)) + 24'(W_GREEN * 24'(green))
               + 24'(W_BLUE * 24'(blue));
    count_next = in_room ? cell_index + CNT_W'(1) : cell_index;
    ovf_next   = overflow_seen | ~in_room;
    item_next.gray   = gray_acc[23:16];
    item_next.idx    = cell_index[IDX_W-1:0];
    item_next.wr_en  = in_room;
    item_next.cmp_en = in_room && (cell_index < prior_count);
    item_next.last   = frame_last;
    item_next.comp   = !ovf_next && (prior_count != '0) && (prior_count == count_next);
    item_next.count  = count_next;
    item_next.ovf    = ovf_next;
    item_next.limit  = LIM_W'(avg_limit_x16 * LIM_W'(count_next));
  end

  // Reread the held request's cell while stalled
  assign rd_addr = advance ? cell_index[IDX_W-1:0] : s1.idx;

  // Frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_index    <= '0;
      prior_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (frame_last) begin
        cell_index    <= '0;
        overflow_seen <= 1'b0;
        prior_count   <= ovf_next ? '0 : count_next;
      end else begin
        cell_index    <= count_next;
        overflow_seen <= ovf_next;
      end
    end
  end

  // Advance stage 1 and flag a read that misses the write in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd.hit  <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      fwd.hit  <= accept && s1_valid && s1.wr_en && item_next.cmp_en
                  && (s1.idx == item_next.idx);
      fwd.gray <= s1.gray;
    end else begin
      fwd.hit  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= item_next;
    end
  end

endmodule

/* hw/rtl/fdd_accum.sv */
// Difference accumulation, frame decision and output register.
// Depends on fdd_pkg; takes requests from fdd_front and data from fdd_sig_ram.
module fdd_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      s1_valid,
  input  fdd_pkg::item_t            s1,
  input  fdd_pkg::fwd_t             fwd,
  input  logic [fdd_pkg::PIX_W-1:0] rdata,
  input  logic [7:0]                max_limit,
  output logic                      wr_en,
  output logic                      out_valid,
  output logic                      is_duplicate,
  output logic                      comparable,
  output logic [7:0]                peak_difference,
  output logic [17:0]               difference_total,
  output logic [10:0]               cell_total,
  output logic                      overflowed
);
  import fdd_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic [PIX_W-1:0] running_peak;

  logic [PIX_W-1:0] old_gray;
  logic [PIX_W-1:0] diff;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_next;
  logic [PIX_W-1:0] peak_next;

  logic             s2_valid;
  logic             s2_comp;
  logic [SUM_W-1:0] s2_sum;
  logic [PIX_W-1:0] s2_peak;
  logic [CNT_W-1:0] s2_count;
  logic             s2_ovf;
  logic [LIM_W-1:0] s2_limit;
  logic             dup;

  assign wr_en = advance && s1_valid && s1.wr_en;

  // Compare cell against stored signature
  always_comb begin
    old_gray  = fwd.hit ? fwd.gray : rdata;
    diff      = (old_gray > s1.gray) ? old_gray - s1.gray : s1.gray - old_gray;
    sum_wide  = (SUM_W + 1)'(running_sum) + (SUM_W + 1)'(diff);
    sum_next  = running_sum;
    peak_next = running_peak;
    if (s1.cmp_en) begin
      sum_next  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      peak_next = (diff > running_peak) ? diff : running_peak;
    end
  end

  // Hold accumulators; drop them at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      running_peak <= '0;
    end else if (advance && s1_valid) begin
      if (s1.last) begin
        running_sum  <= '0;
        running_peak <= '0;
      end else begin
        running_sum  <= sum_next;
        running_peak <= peak_next;
      end
    end
  end

  // Frame totals stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_comp  <= s1.comp;
      s2_sum   <= s1.comp ? sum_next : '0;
      s2_peak  <= s1.comp ? peak_next : '0;
      s2_count <= s1.count;
      s2_ovf   <= s1.ovf;
      s2_limit <= s1.limit;
    end
  end

  // Duplicate decision
  assign dup = s2_comp && (s2_sum != SUM_MAX)
               && (CMP_W'({s2_sum, 4'b0000}) <= CMP_W'(s2_limit))
               && (s2_peak <= max_limit);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_duplicate     <= dup;
      comparable       <= s2_comp;
      peak_difference  <= s2_peak;
      difference_total <= s2_sum;
      cell_total       <= OUT_CNT_W'(s2_count);
      overflowed       <= s2_ovf;
    end
  end

endmodule

/* hw/rtl/frame_duplicate_detector.sv */
// Top level of the frame duplicate detector: config registers and stall control.
// Depends on fdd_pkg, fdd_front, fdd_accum and fdd_sig_ram.
//
//  channel | signals                                   | dir | request
//  in      | in_valid/in_ready, red, green, blue,      | in  | one grid pixel
//          | frame_last                                |     |
//  out     | out_valid/out_ready, is_duplicate,        | out | one frame verdict
//          | comparable, peak_difference,              |     |
//          | difference_total, cell_total, overflowed  |     |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in  | one register write
//
// One pixel per cycle unless stalled; the verdict is registered in s1, s2, then output.
// Rate is set by the signature memory: one read and one write per pixel, with
// a bypass when a one-cell frame is followed by a read of the same cell.
// The whole pipeline stalls only while a verdict sits in the output register
// unaccepted. Reset is synchronous; no clearing pass, the memory needs none.
module frame_duplicate_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_duplicate,
  output logic                          comparable,
  output logic [7:0]                    peak_difference,
  output logic [17:0]                   difference_total,
  output logic [10:0]                   cell_total,
  output logic                          overflowed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import fdd_pkg::*;

  logic [AVG_W-1:0] avg_limit_x16;
  logic [7:0]       max_limit;
  logic             advance;
  logic             s1_valid;
  item_t            s1;
  fwd_t             fwd;
  logic [IDX_W-1:0] rd_addr;
  logic [PIX_W-1:0] rdata;
  logic             wr_en;

  // Advance everything unless the output holds an unaccepted verdict
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_limit_x16 <= AVG_W'(16);
      max_limit     <= 8'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AVG_LIMIT: avg_limit_x16 <= cfg_data[AVG_W-1:0];
        REG_MAX_LIMIT: max_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fdd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (in_valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .frame_last    (frame_last),
    .avg_limit_x16 (avg_limit_x16),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .fwd           (fwd),
    .rd_addr       (rd_addr)
  );

  fdd_sig_ram u_sig_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.idx),
    .wdata (s1.gray),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  fdd_accum u_accum (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .s1_valid         (s1_valid),
    .s1               (s1),
    .fwd              (fwd),
    .rdata            (rdata),
    .max_limit        (max_limit),
    .wr_en            (wr_en),
    .out_valid        (out_valid),
    .is_duplicate     (is_duplicate),
    .comparable       (comparable),
    .peak_difference  (peak_difference),
    .difference_total (difference_total),
    .cell_total       (cell_total),
    .overflowed       (overflowed)
  );

endmodule
